[hdl/spct_pkg.sv]
// ----------------------------------------------------------------------------
// Package for the sphere pair collision time core
// Shared widths, status codes, the register map and the pipeline record types.
// ----------------------------------------------------------------------------
`default_nettype none
package spct_pkg;
  localparam int CoordW = 32;
  localparam int DistW  = 31;
  localparam int TimeW  = 32;
  localparam int StatW  = 3;
  localparam int DiffW  = 33;
  localparam int ProdW  = 66;
  localparam int BW     = 68;
  localparam int CW     = 68;
  localparam int DiscW  = 140;
  localparam int RootW  = 70;
  localparam int DenW   = 72;
  localparam int AddrW  = 1;
  localparam int DataW  = 32;

  localparam logic [StatW-1:0] ST_HIT   = 3'd0;
  localparam logic [StatW-1:0] ST_SAME  = 3'd1;
  localparam logic [StatW-1:0] ST_APART = 3'd2;
  localparam logic [StatW-1:0] ST_MISS  = 3'd3;
  localparam logic [StatW-1:0] ST_STILL = 3'd4;

  localparam logic [AddrW-1:0] REG_CONTACT = 1'b0;
  localparam logic [DistW-1:0] CONTACT_RESET = 31'd13107;

  typedef struct packed {
    logic [CoordW-1:0] first_pos_x;
    logic [CoordW-1:0] first_pos_y;
    logic [CoordW-1:0] first_pos_z;
    logic [CoordW-1:0] first_vel_x;
    logic [CoordW-1:0] first_vel_y;
    logic [CoordW-1:0] first_vel_z;
    logic [CoordW-1:0] second_pos_x;
    logic [CoordW-1:0] second_pos_y;
    logic [CoordW-1:0] second_pos_z;
    logic [CoordW-1:0] second_vel_x;
    logic [CoordW-1:0] second_vel_y;
    logic [CoordW-1:0] second_vel_z;
  } pair_t;

  typedef struct packed {
    logic [TimeW-1:0] hit_time;
    logic [StatW-1:0] status;
    logic             time_clipped;
  } result_t;

  typedef struct packed {
    logic              done;
    logic [StatW-1:0]  status;
    logic              neg;
    logic [DenW-1:0]   den;
    logic [DenW-1:0]   rem;
    logic [DenW-1:0]   quo;
  } div_cell_t;
endpackage
`default_nettype wire

[hdl/spct_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Valid and ready handshake carrying a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface spct_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/spct_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// Decides one root bit per enabled cycle by restoring and passes the rest on.
// ----------------------------------------------------------------------------
`default_nettype none
module spct_sqrt_cell import spct_pkg::*; #(
  parameter int BitPos = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DiscW-1:0] rem_in,
  input  wire logic [RootW-1:0] root_in,
  output logic      [DiscW-1:0] rem_out,
  output logic      [RootW-1:0] root_out
);
  logic [DiscW+1:0] trial;
  always_comb begin
    trial = ((DiscW+2)'(root_in) << (BitPos + 1)) | ((DiscW+2)'(1) << (2 * BitPos));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if ({2'b00, rem_in} >= trial) begin
        rem_out  <= rem_in - trial[DiscW-1:0];
        root_out <= root_in | (RootW'(1) << BitPos);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/spct_div_cell.sv]
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of the time division, passing the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module spct_div_cell import spct_pkg::*; #(
  parameter int NumBit = 0
) (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire logic      num_bit,
  input  wire div_cell_t cell_in,
  output div_cell_t      cell_out
);
  logic [DenW:0] shifted;
  div_cell_t cell_next;
  always_comb begin
    shifted = {cell_in.rem, num_bit};
    cell_next = cell_in;
    if (shifted >= {1'b0, cell_in.den}) begin
      cell_next.rem = DenW'(shifted - {1'b0, cell_in.den});
      cell_next.quo = {cell_in.quo[DenW-2:0], 1'b1};
    end else begin
      cell_next.rem = shifted[DenW-1:0];
      cell_next.quo = {cell_in.quo[DenW-2:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cell_out <= cell_next;
    end
  end
endmodule
`default_nettype wire

[hdl/sphere_pair_collision_time_core.sv]
// ----------------------------------------------------------------------------
// Sphere pair collision time core
// Predicts when two moving hard spheres touch.
// ----------------------------------------------------------------------------
// A request on the pair channel carries two spheres' positions and velocities
// in signed fixed point. Each request gives one result on the result channel:
// the time until contact, a status code and a saturation flag.
// One request is accepted every cycle unless the result stalls. Products and
// sums pass the front stages, then the square root row has one cell per root
// bit, the division row one cell per numerator bit, then one output register.
// The contact distance register sits on the APB port at address 0; it is to
// be written only while the core is empty, which the core does not enforce.
// All cells advance together; when the result is not taken the whole row holds
// and the pair channel drops ready. Reset clears every valid flag and returns
// the contact distance to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_pair_collision_time_core import spct_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  spct_if.sink                  pair,
  spct_if.source                result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);
  localparam int NumW   = CW + FRAC_BITS;
  localparam int Front  = 6;
  localparam int SqSteps = RootW;
  localparam int Depth  = Front + SqSteps + NumW + 1;
  localparam int HalfW  = BW / 2;

  logic [DistW-1:0] contact_distance;
  logic en;
  logic [Depth-1:0] vld;

  assign pready = 1'b1;
  assign prdata = {1'b0, contact_distance};
  always_ff @(posedge clk) begin
    if (rst) begin
      contact_distance <= CONTACT_RESET;
    end else if (psel && penable && pwrite && paddr == REG_CONTACT) begin
      contact_distance <= pwdata[DistW-1:0];
    end
  end

  assign en = !result.valid || result.ready;
  assign pair.ready = en;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], pair.valid};
    end
  end
  assign result.valid = vld[Depth-1];

  // Stage 1: differences and identity.
  logic signed [DiffW-1:0] dx [3];
  logic signed [DiffW-1:0] dv [3];
  logic same1;
  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= DiffW'($signed(pair.data.second_pos_x)) - DiffW'($signed(pair.data.first_pos_x));
      dx[1] <= DiffW'($signed(pair.data.second_pos_y)) - DiffW'($signed(pair.data.first_pos_y));
      dx[2] <= DiffW'($signed(pair.data.second_pos_z)) - DiffW'($signed(pair.data.first_pos_z));
      dv[0] <= DiffW'($signed(pair.data.second_vel_x)) - DiffW'($signed(pair.data.first_vel_x));
      dv[1] <= DiffW'($signed(pair.data.second_vel_y)) - DiffW'($signed(pair.data.first_vel_y));
      dv[2] <= DiffW'($signed(pair.data.second_vel_z)) - DiffW'($signed(pair.data.first_vel_z));
      same1 <= pair.data[12*CoordW-1:6*CoordW] == pair.data[6*CoordW-1:0];
    end
  end

  // Stage 2: products.
  logic signed [ProdW-1:0] pb [3];
  logic signed [ProdW-1:0] pa [3];
  logic signed [ProdW-1:0] pc [3];
  logic [2*DistW-1:0] sig2;
  logic same2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pb[i] <= dx[i] * dv[i];
        pa[i] <= dv[i] * dv[i];
        pc[i] <= dx[i] * dx[i];
      end
      sig2  <= contact_distance * contact_distance;
      same2 <= same1;
    end
  end

  // Stage 3: sums.
  logic signed [BW-1:0] b3, a3, c3;
  logic same3;
  always_ff @(posedge clk) begin
    if (en) begin
      b3 <= BW'(pb[0]) + BW'(pb[1]) + BW'(pb[2]);
      a3 <= BW'(pa[0]) + BW'(pa[1]) + BW'(pa[2]);
      c3 <= CW'(pc[0]) + CW'(pc[1]) + CW'(pc[2]) - CW'({1'b0, sig2});
      same3 <= same2;
    end
  end

  // Stage 4: partial products of the discriminant squares, split into halves.
  logic [2*HalfW-1:0] bb_ll4, ac_ll4;
  logic signed [2*HalfW:0] bb_hl4, ac_hl4, ac_lh4;
  logic signed [2*HalfW-1:0] bb_hh4, ac_hh4;
  logic signed [BW-1:0] b4, a4, c4;
  logic same4;
  always_ff @(posedge clk) begin
    if (en) begin
      bb_ll4 <= b3[HalfW-1:0] * b3[HalfW-1:0];
      bb_hl4 <= $signed(b3[BW-1:HalfW]) * $signed({1'b0, b3[HalfW-1:0]});
      bb_hh4 <= $signed(b3[BW-1:HalfW]) * $signed(b3[BW-1:HalfW]);
      ac_ll4 <= a3[HalfW-1:0] * c3[HalfW-1:0];
      ac_hl4 <= $signed(a3[BW-1:HalfW]) * $signed({1'b0, c3[HalfW-1:0]});
      ac_lh4 <= $signed({1'b0, a3[HalfW-1:0]}) * $signed(c3[BW-1:HalfW]);
      ac_hh4 <= $signed(a3[BW-1:HalfW]) * $signed(c3[BW-1:HalfW]);
      b4 <= b3; a4 <= a3; c4 <= c3;
      same4 <= same3;
    end
  end

  // Stage 5: squares for the discriminant.
  logic signed [DiscW-1:0] bb5, ac5;
  logic signed [BW-1:0] b5, a5, c5;
  logic same5;
  always_ff @(posedge clk) begin
    if (en) begin
      bb5 <= (DiscW'(bb_hh4) << (2 * HalfW)) + (DiscW'(bb_hl4) << (HalfW + 1))
           + DiscW'(bb_ll4);
      ac5 <= (DiscW'(ac_hh4) << (2 * HalfW)) + ((DiscW'(ac_hl4) + DiscW'(ac_lh4)) << HalfW)
           + DiscW'(ac_ll4);
      b5 <= b4; a5 <= a4; c5 <= c4;
      same5 <= same4;
    end
  end

  // Stage 6: discriminant and status.
  logic [DiscW-1:0] disc6;
  logic signed [BW-1:0] b6, c6;
  logic [StatW-1:0] st6;
  always_ff @(posedge clk) begin
    if (en) begin
      disc6 <= bb5 - ac5;
      b6 <= b5; c6 <= c5;
      if (same5) begin
        st6 <= ST_SAME;
      end else if (!b5[BW-1] && b5 != '0) begin
        st6 <= ST_APART;
      end else if (bb5 < ac5) begin
        st6 <= ST_MISS;
      end else if (a5 == '0) begin
        st6 <= ST_STILL;
      end else begin
        st6 <= ST_HIT;
      end
    end
  end

  // Square root row.
  logic [DiscW-1:0] sq_rem  [SqSteps+1];
  logic [RootW-1:0] sq_root [SqSteps+1];
  logic signed [BW-1:0] sq_b [SqSteps+1];
  logic signed [BW-1:0] sq_c [SqSteps+1];
  logic [StatW-1:0] sq_st [SqSteps+1];
  assign sq_rem[0]  = (st6 == ST_HIT) ? disc6 : '0;
  assign sq_root[0] = '0;
  assign sq_b[0] = b6;
  assign sq_c[0] = c6;
  assign sq_st[0] = st6;
  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    spct_sqrt_cell #(.BitPos(SqSteps - 1 - g)) u_cell (
      .clk(clk), .en(en),
      .rem_in(sq_rem[g]), .root_in(sq_root[g]),
      .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_b[g+1] <= sq_b[g];
        sq_c[g+1] <= sq_c[g];
        sq_st[g+1] <= sq_st[g];
      end
    end
  end

  // Division row.
  logic [NumW-1:0] num [NumW+1];
  div_cell_t dc [NumW+1];
  logic [CW-1:0] cmag;
  always_comb begin
    cmag = sq_c[SqSteps][CW-1] ? CW'(-sq_c[SqSteps]) : CW'(sq_c[SqSteps]);
    dc[0].done = 1'b0;
    dc[0].status = sq_st[SqSteps];
    dc[0].neg = sq_c[SqSteps][CW-1];
    dc[0].den = DenW'(sq_root[SqSteps]) - DenW'(sq_b[SqSteps]);
    dc[0].rem = '0;
    dc[0].quo = '0;
  end
  assign num[0] = {cmag, FRAC_BITS'(0)};
  for (genvar g = 0; g < NumW; g++) begin : g_div
    spct_div_cell #(.NumBit(NumW - 1 - g)) u_cell (
      .clk(clk), .en(en), .num_bit(num[g][NumW-1]),
      .cell_in(dc[g]), .cell_out(dc[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        num[g+1] <= {num[g][NumW-2:0], 1'b0};
      end
    end
  end

  // Output register: saturation and sign.
  div_cell_t fin;
  logic big;
  result_t res;
  assign fin = dc[NumW];
  always_comb begin
    big = fin.quo[DenW-1:TimeW] != '0;
    res = '0;
    res.status = fin.status;
    if (fin.status == ST_HIT && fin.den != '0) begin
      if (fin.neg) begin
        if (big || fin.quo[TimeW-1:0] > 32'h8000_0000) begin
          res.hit_time = 32'h8000_0000;
          res.time_clipped = 1'b1;
        end else begin
          res.hit_time = -fin.quo[TimeW-1:0];
        end
      end else if (big || fin.quo[TimeW-1]) begin
        res.hit_time = 32'h7fff_ffff;
        res.time_clipped = 1'b1;
      end else begin
        res.hit_time = fin.quo[TimeW-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      result.data <= res;
    end
  end
endmodule
`default_nettype wire

[hdl/spct_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the sphere pair collision time core
// Watches the result channel, pair ready and the register port over time.
// ----------------------------------------------------------------------------
`default_nettype none
module spct_checker import spct_pkg::*; (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          pair_ready,
  input wire logic          res_valid,
  input wire logic          res_ready,
  input wire result_t       res_data,
  input wire logic          pready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("result dropped");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !pair_ready) else $error("accepted while stalled");
  a_clip: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_HIT |-> res_data.hit_time == '0 && !res_data.time_clipped)
    else $error("non-hit carries a time");
  a_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.status <= ST_STILL) else $error("bad status");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind sphere_pair_collision_time_core spct_checker u_spct_checker (
  .clk(clk), .rst(rst), .pair_ready(pair.ready), .res_valid(result.valid),
  .res_ready(result.ready), .res_data(result.data), .pready(pready)
);
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Sphere pair collision time core testbench
// Streams pairs of spheres through the core under random idling on both sides,
// predicts every result with exact wide integer arithmetic, and compares the
// results in order. The contact distance is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import spct_pkg::*;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [199:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic pready;

  spct_if #(.payload_t(pair_t)) pair_ch (clk);
  spct_if #(.payload_t(result_t)) result_ch (clk);

  sphere_pair_collision_time_core #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .pair(pair_ch.sink), .result(result_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pair_t pending_pairs[$];
  result_t expected_results[$];
  logic [DistW-1:0] contact_model;
  int errors = 0;
  int cycle = 0;
  int stall_count = 0;

  always #5 clk = ~clk;

  function automatic result_t predict_collision(pair_t p, logic [DistW-1:0] cd);
    logic [383:0] bits;
    logic [31:0] f [12];
    wide_t dx, dv, b, a, c, disc, root, cand, den, mag, q;
    result_t r;
    logic neg;
    bits = p;
    for (int i = 0; i < 12; i++) f[i] = bits[383-32*i -: 32];
    b = 0; a = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      dx = $signed(f[6+i]) - $signed(f[i]);
      dv = $signed(f[9+i]) - $signed(f[3+i]);
      b = b + dx * dv;
      a = a + dv * dv;
      c = c + dx * dx;
    end
    c = c - $signed({1'b0, cd}) * $signed({1'b0, cd});
    disc = b * b - a * c;
    r = '0;
    if (bits[383:192] == bits[191:0]) begin
      r.status = ST_SAME;
    end else if (b > 0) begin
      r.status = ST_APART;
    end else if (disc < 0) begin
      r.status = ST_MISS;
    end else if (a == 0) begin
      r.status = ST_STILL;
    end else begin
      r.status = ST_HIT;
      root = 0;
      for (int k = 95; k >= 0; k--) begin
        cand = root | (wide_t'(1) << k);
        if (cand * cand <= disc) root = cand;
      end
      den = root - b;
      neg = c < 0;
      mag = (neg ? -c : c) <<< FRAC;
      q = (den == 0) ? wide_t'(0) : mag / den;
      if (neg) begin
        if (q > 64'sh80000000) begin
          r.hit_time = 32'h80000000; r.time_clipped = 1'b1;
        end else begin
          r.hit_time = -q[31:0];
        end
      end else if (q > 64'sh7FFFFFFF) begin
        r.hit_time = 32'h7FFFFFFF; r.time_clipped = 1'b1;
      end else begin
        r.hit_time = q[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic side_active();
    return (cycle >= 3000 && cycle < 6000) || ($urandom_range(0, 99) >= 20);
  endfunction

  // Request driver and predictor
  always @(posedge clk) begin
    if (pair_ch.valid && pair_ch.ready)
      expected_results.push_back(predict_collision(pair_ch.data, contact_model));
    if (!rst && (!pair_ch.valid || pair_ch.ready)) begin
      if (pending_pairs.size() > 0 && side_active()) begin
        pair_ch.valid <= 1'b1;
        pair_ch.data <= pending_pairs.pop_front();
      end else begin
        pair_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t exp_r;
    result_ch.ready <= !rst && side_active();
    if (result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, result_ch.data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.hit_time !== result_ch.data.hit_time) begin
          $display("%0t: hit_time expected %h actual %h", $time, exp_r.hit_time,
                   result_ch.data.hit_time);
          errors++;
        end
        if (exp_r.status !== result_ch.data.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   result_ch.data.status);
          errors++;
        end
        if (exp_r.time_clipped !== result_ch.data.time_clipped) begin
          $display("%0t: time_clipped expected %b actual %b", $time,
                   exp_r.time_clipped, result_ch.data.time_clipped);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if ((pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (pending_pairs.size() == 0 && expected_results.size() == 0)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task automatic add_pair(input logic [31:0] px, py, pz, vx, vy, vz,
                          input logic [31:0] qx, qy, qz, wx, wy, wz);
    pending_pairs.push_back({px, py, pz, vx, vy, vz, qx, qy, qz, wx, wy, wz});
  endtask

  task automatic write_contact(input logic [DataW-1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_CONTACT; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    contact_model = value[DistW-1:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || expected_results.size() > 0 || pair_ch.valid)
      @(posedge clk);
  endtask

  task automatic add_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    add_pair(one, one, one, one, one, one, one, one, one, one, one, one);
    add_pair(0, 0, 0, 0, 0, 0, 4 * one, 0, 0, one, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 4 * one, one, 0, -one, 0, 0);
    add_pair(0, 0, 0, 5, 5, 5, 4 * one, 0, 0, 5, 5, 5);
    add_pair(0, 0, 0, 0, 0, 0, 4 * one, 0, 0, -one, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 100, 0, 0, -one, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 32'd13107, 0, 0, -one, 0, 0);
    add_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, -1, 0, 0);
    add_pair(32'h80000000, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, -1, 0, 0);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF);
    add_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
             32'h80000000, 32'h80000000);
    add_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h80000000);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic add_random(input int count);
    logic [31:0] fp [3];
    logic [31:0] fv [3];
    logic [31:0] sp [3];
    logic [31:0] sv [3];
    int signed off;
    int sh;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 60) begin
        sh = $urandom_range(0, 6);
        for (int i = 0; i < 3; i++) begin
          fp[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
          fv[i] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          off = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          sp[i] = fp[i] + off;
          sv[i] = fv[i] - (off >>> sh) + $urandom_range(0, 64) - 32;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          fp[i] = $urandom; fv[i] = $urandom; sp[i] = $urandom; sv[i] = $urandom;
        end
      end
      add_pair(fp[0], fp[1], fp[2], fv[0], fv[1], fv[2],
               sp[0], sp[1], sp[2], sv[0], sv[1], sv[2]);
    end
  endtask

  initial begin
    logic [DataW-1:0] settings [5];
    pair_ch.valid = 1'b0;
    pair_ch.data = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    contact_model = CONTACT_RESET;
    settings = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, $urandom, 32'h0000_3333};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(150);
    wait_drained();
    foreach (settings[s]) begin
      write_contact(settings[s]);
      add_directed();
      add_random(150);
      wait_drained();
    end
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[files.f]
hdl/spct_pkg.sv
hdl/spct_if.sv
hdl/spct_sqrt_cell.sv
hdl/spct_div_cell.sv
hdl/sphere_pair_collision_time_core.sv
hdl/spct_checker.sv
bench/testbench.sv
